// File: hdl/lfu_pkg.sv
package lfu_pkg;

  // fixed field widths
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  // default sizing
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

  // operation codes
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

endpackage

// File: hdl/lfu_cache_replacement_top.sv
// a request is accepted in idle, then the scan reads every entry of the entry memory,
//   the last read data is checked, the scan is left, the update writes and the output
//   register loads; no new request is accepted until the sequencer is back in idle,
//   and a finished result waits while the output is held
// reset: valid bits cleared (table empty), capacity back to 16;
//   entry memory and recency ranks are not cleared and need no clearing pass
module lfu_cache_replacement_top #(
  parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
  parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // capacity register
  input  logic                              cfg_write_en,
  input  logic [lfu_pkg::CAP_W-1:0]         cfg_write_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic signed [lfu_pkg::DATA_W-1:0] key,
  input  logic signed [lfu_pkg::DATA_W-1:0] write_value,
  // response channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic signed [lfu_pkg::DATA_W-1:0] read_value,
  output logic                              evicted
);
  import lfu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  // one stored entry
  typedef struct packed {
    logic [DATA_W-1:0]     key;
    logic [DATA_W-1:0]     value;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  logic [1:0]            state;
  logic [CAP_W-1:0]      cache_capacity;
  logic [ENTRIES-1:0]    slot_valid;
  logic [OCC_W-1:0]      occ;

  // recency per slot: 0 is the most recent valid entry, larger is older
  logic [IDX_W-1:0]      recency_rank [ENTRIES];

  // latched request
  logic                  kind_r;
  logic [DATA_W-1:0]     key_r;
  logic [DATA_W-1:0]     wval_r;

  // scan pipeline: address issue, then registered read data
  logic [IDX_W:0]        scan_idx;
  logic                  issue;
  logic                  rd_live;
  logic                  rd_vld;
  logic [IDX_W-1:0]      rd_idx;
  logic [IDX_W-1:0]      rd_rank;
  entry_t                rd_data;
  entry_t                mem [ENTRIES];

  // scan results
  logic                  match_found;
  logic [IDX_W-1:0]      match_idx;
  logic [DATA_W-1:0]     match_value;
  logic [COUNT_BITS-1:0] match_count;
  logic                  vic_found;
  logic [IDX_W-1:0]      vic_idx;
  logic [COUNT_BITS-1:0] vic_count;
  logic [IDX_W-1:0]      vic_rank;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;

  // result waiting for the output register
  logic                  res_hit;
  logic [DATA_W-1:0]     res_value;
  logic                  res_evicted;

  // update decode
  logic [CMP_W-1:0]      cap_full;
  logic [CMP_W-1:0]      cap_eff;
  logic                  table_full;
  logic                  put_live;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  entry_t                mem_wdata;
  logic                  insert_free;
  logic                  better;
  logic                  in_fire;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign issue    = (state == ST_SCAN) && (scan_idx < (IDX_W+1)'(ENTRIES));

  // capacity above the table size acts as the table size
  assign cap_full   = CMP_W'(cache_capacity);
  assign cap_eff    = (cap_full > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_full;
  assign table_full = CMP_W'(occ) >= cap_eff;
  assign put_live   = (kind_r == KIND_PUT) && (cap_eff != '0);
  assign count_inc  = (match_count == '1) ? match_count : match_count + COUNT_BITS'(1);

  // victim order: lower count first, then older (larger rank)
  assign better = !vic_found || (rd_data.count < vic_count) ||
                  ((rd_data.count == vic_count) && (rd_rank > vic_rank));

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = match_idx;
    insert_free = 1'b0;
    mem_wdata   = '{key: key_r, value: wval_r, count: count_inc};
    if (state == ST_UPDATE) begin
      if (kind_r == KIND_GET) begin
        if (match_found) begin
          mem_we          = 1'b1;
          mem_wdata.value = match_value;
        end
      end else if (put_live) begin
        mem_we = 1'b1;
        if (!match_found) begin
          mem_wdata.count = COUNT_BITS'(1);
          if (table_full) begin
            // evict and reuse the victim's slot
            mem_waddr = vic_idx;
          end else begin
            mem_waddr   = free_idx;
            insert_free = 1'b1;
          end
        end
      end
    end
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data <= mem[scan_idx[IDX_W-1:0]];
    end
  end

  // written slot becomes most recent; a fresh insert ages every valid entry,
  // a hit or a victim reuse ages only the entries that were more recent
  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == mem_waddr) begin
          recency_rank[i] <= '0;
        end else if (slot_valid[i] &&
                     (insert_free || (recency_rank[i] < recency_rank[mem_waddr]))) begin
          recency_rank[i] <= recency_rank[i] + IDX_W'(1);
        end
      end
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_capacity <= CAP_RESET;
    end else if (cfg_write_en) begin
      cache_capacity <= cfg_write_data;
    end
  end

  // request latch and scan bookkeeping
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= kind;
      key_r  <= key;
      wval_r <= write_value;
    end
    if (issue) begin
      rd_idx  <= scan_idx[IDX_W-1:0];
      rd_vld  <= slot_valid[scan_idx[IDX_W-1:0]];
      rd_rank <= recency_rank[scan_idx[IDX_W-1:0]];
    end
    if (rd_live) begin
      if (rd_vld) begin
        if (rd_data.key == key_r) begin
          match_idx   <= rd_idx;
          match_value <= rd_data.value;
          match_count <= rd_data.count;
        end
        if (better) begin
          vic_idx   <= rd_idx;
          vic_count <= rd_data.count;
          vic_rank  <= rd_rank;
        end
      end else if (!free_found) begin
        free_idx <= rd_idx;
      end
    end
    if (state == ST_UPDATE) begin
      res_hit     <= match_found;
      res_evicted <= put_live && !match_found && table_full;
      if (kind_r == KIND_GET) begin
        res_value <= match_found ? match_value : MISS_VALUE;
      end else begin
        res_value <= PUT_VALUE;
      end
    end
    if ((state == ST_DONE) && (!out_valid || out_ready)) begin
      hit        <= res_hit;
      read_value <= res_value;
      evicted    <= res_evicted;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      scan_idx    <= '0;
      rd_live     <= 1'b0;
      match_found <= 1'b0;
      vic_found   <= 1'b0;
      free_found  <= 1'b0;
      slot_valid  <= '0;
      occ         <= '0;
      out_valid   <= 1'b0;
    end else begin
      rd_live <= issue;
      // in the done state the output load below decides valid
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      if (rd_live) begin
        if (rd_vld) begin
          if (rd_data.key == key_r) begin
            match_found <= 1'b1;
          end
          vic_found <= 1'b1;
        end else begin
          free_found <= 1'b1;
        end
      end
      if (insert_free) begin
        slot_valid[free_idx] <= 1'b1;
        occ                  <= occ + OCC_W'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state       <= ST_SCAN;
            scan_idx    <= '0;
            match_found <= 1'b0;
            vic_found   <= 1'b0;
            free_found  <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + (IDX_W+1)'(1);
          end else if (!rd_live) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/sv/lfu_cache_replacement_top_tb.sv
`timescale 1ns / 1ps

module lfu_cache_replacement_top_tb;
  import lfu_pkg::*;

  // narrow use counts so saturation is reachable in a short run
  localparam int TB_ENTRIES     = DEF_ENTRIES;
  localparam int TB_COUNT_BITS  = 4;
  localparam int COUNT_CEIL     = (1 << TB_COUNT_BITS) - 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_TAIL     = 2 * (TB_ENTRIES + 3);
  localparam int POOL_MAX       = 24;
  localparam int REPORT_MAX     = 10;

  typedef struct {
    logic              op;
    logic [DATA_W-1:0] key;
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
  } cache_reply_t;

  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              cfg_write_en   = 1'b0;
  logic [CAP_W-1:0]  cfg_write_data = '0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic              kind           = KIND_GET;
  logic [DATA_W-1:0] key            = '0;
  logic [DATA_W-1:0] write_value    = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic              hit;
  logic [DATA_W-1:0] read_value;
  logic              evicted;

  lfu_cache_replacement_top #(
    .ENTRIES    (TB_ENTRIES),
    .COUNT_BITS (TB_COUNT_BITS)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .key            (key),
    .write_value    (write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .read_value     (read_value),
    .evicted        (evicted)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow copy of the cache
  // recency is kept as an access sequence number: larger means more recent
  // ---------------------------------------------------------------------------
  bit                ent_live  [TB_ENTRIES];
  logic [DATA_W-1:0] ent_key   [TB_ENTRIES];
  logic [DATA_W-1:0] ent_data  [TB_ENTRIES];
  int unsigned       ent_uses  [TB_ENTRIES];
  longint unsigned   ent_stamp [TB_ENTRIES];
  longint unsigned   access_seq     = 0;
  logic [CAP_W-1:0]  capacity_model = CAP_RESET;

  cache_reply_t pending_replies [$];

  // pacing knobs, percent of cycles spent idle
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  int unsigned fail_count   = 0;
  int unsigned get_count    = 0;
  int unsigned put_count    = 0;
  int unsigned hit_count    = 0;
  int unsigned evict_count  = 0;
  int unsigned cap_writes   = 0;
  int unsigned quiet_cycles = 0;

  logic [DATA_W-1:0] key_pool [POOL_MAX];

  // hit bumps the use count (saturating) and makes the entry most recent
  task automatic refresh_entry(input int slot);
    if (ent_uses[slot] < COUNT_CEIL) ent_uses[slot]++;
    access_seq++;
    ent_stamp[slot] = access_seq;
  endtask

  // compute the reply for one request and update the shadow cache
  task automatic cache_lookup(input logic op, input logic [DATA_W-1:0] k,
                              input logic [DATA_W-1:0] v, output cache_reply_t r);
    int slot;
    int held;
    int room;
    int victim;
    int target;
    slot   = -1;
    held   = 0;
    victim = -1;
    target = -1;
    for (int i = 0; i < TB_ENTRIES; i++) begin
      if (ent_live[i]) begin
        held++;
        if (ent_key[i] == k) slot = i;
      end
    end
    // register values past the table size act as a full table
    room = (capacity_model > TB_ENTRIES) ? TB_ENTRIES : int'(capacity_model);
    r.op         = op;
    r.key        = k;
    r.hit        = (slot >= 0);
    r.read_value = PUT_VALUE;
    r.evicted    = 1'b0;
    if (op == KIND_GET) begin
      if (slot >= 0) begin
        r.read_value = ent_data[slot];
        refresh_entry(slot);
      end else begin
        r.read_value = MISS_VALUE;
      end
    end else if (room != 0) begin
      if (slot >= 0) begin
        ent_data[slot] = v;
        refresh_entry(slot);
      end else begin
        if (held >= room) begin
          // lowest count loses, oldest access breaks ties
          for (int i = 0; i < TB_ENTRIES; i++) begin
            if (ent_live[i] && (victim < 0 || ent_uses[i] < ent_uses[victim] ||
                (ent_uses[i] == ent_uses[victim] && ent_stamp[i] < ent_stamp[victim])))
              victim = i;
          end
          ent_live[victim] = 1'b0;
          target           = victim;
          r.evicted        = 1'b1;
        end else begin
          for (int i = 0; i < TB_ENTRIES; i++)
            if (!ent_live[i] && target < 0) target = i;
        end
        access_seq++;
        ent_live[target]  = 1'b1;
        ent_key[target]   = k;
        ent_data[target]  = v;
        ent_uses[target]  = 1;
        ent_stamp[target] = access_seq;
      end
    end
  endtask

  task automatic log_failure(input string msg);
    if (fail_count < REPORT_MAX) $display("%0t ERROR %s", $realtime, msg);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // request side: one word per call, valid held until accepted
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic op, input logic [DATA_W-1:0] k,
                              input logic [DATA_W-1:0] v);
    cache_reply_t r;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= op;
    key         <= k;
    write_value <= v;
    do @(posedge clk); while (!in_ready);
    cache_lookup(op, k, v, r);
    pending_replies.push_back(r);
    if (op == KIND_GET) get_count++;
    else put_count++;
  endtask

  // drop valid and let every outstanding reply come back
  task automatic drain_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // capacity is only changed with the pipeline empty
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain_replies();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= cap;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    capacity_model = cap;
    cap_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // response side: random backpressure and reply checking
  // ---------------------------------------------------------------------------
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);

  always @(posedge clk) begin
    cache_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        log_failure($sformatf("unexpected reply hit=%0b value=%08h evicted=%0b",
                              hit, read_value, evicted));
      end else begin
        want = pending_replies.pop_front();
        if (hit !== want.hit || read_value !== want.read_value ||
            evicted !== want.evicted)
          log_failure($sformatf({"%s key %08h: expected hit=%0b value=%08h evicted=%0b,",
                                 " got hit=%0b value=%08h evicted=%0b"},
                                (want.op == KIND_GET) ? "get" : "put", want.key,
                                want.hit, want.read_value, want.evicted,
                                hit, read_value, evicted));
      end
      if (hit === 1'b1) hit_count++;
      if (evicted === 1'b1) evict_count++;
    end
  end

  // watchdog: a long stretch with no word moving on either side means a hang
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t timeout: no word moved for %0d cycles, %0d replies outstanding",
               $realtime, quiet_cycles, pending_replies.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // miss on empty table, extreme keys and values, put over an existing key
  task automatic test_basic_get_put();
    send_request(KIND_GET, 32'h0000_0000, 32'h1234_5678);
    send_request(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(KIND_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
  endtask

  // hammer one key past the count ceiling, then a victim must be the other key
  task automatic test_count_saturation();
    repeat (COUNT_CEIL) send_request(KIND_GET, 32'h8000_0000, $urandom);
    set_capacity(CAP_W'(2));
    send_request(KIND_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    send_request(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
  endtask

  // register lowered under the occupancy: each miss evicts one and inserts one
  task automatic test_capacity_shrink();
    set_capacity(CAP_W'(1));
    send_request(KIND_PUT, 32'h0000_0001, 32'h1111_1111);
    send_request(KIND_PUT, 32'h0000_0002, 32'h2222_2222);
  endtask

  // oversized capacity acts as a full table; equal counts go oldest first
  task automatic test_victim_tie_break();
    set_capacity(CAP_W'(31));
    send_request(KIND_PUT, 32'h0000_0003, 32'h3333_3333);
    set_capacity(CAP_W'(3));
    send_request(KIND_PUT, 32'h0000_0004, 32'h4444_4444);
    send_request(KIND_GET, 32'h0000_0002, 32'h0000_0000);
    send_request(KIND_GET, 32'h0000_0003, 32'h0000_0000);
  endtask

  // zero capacity: puts leave the table alone but still report hits
  task automatic test_capacity_zero();
    set_capacity(CAP_W'(0));
    send_request(KIND_PUT, 32'h0000_0003, 32'hDEAD_BEEF);
    send_request(KIND_PUT, 32'h0000_0005, 32'h5555_5555);
    send_request(KIND_GET, 32'h0000_0005, 32'h0000_0000);
    send_request(KIND_GET, 32'h0000_0003, 32'h0000_0000);
  endtask

  // random gets and puts over a small key pool so hits, evictions and
  // saturation all happen often; pacing rotates through four modes
  task automatic test_random_traffic();
    int unsigned cap_plan  [8] = '{16, 4, 1, 31, 0, 9, 2, 20};
    int unsigned send_plan [4] = '{0, 80, 0, 11};
    int unsigned recv_plan [4] = '{0, 0, 80, 11};
    int unsigned pool_len;
    logic [DATA_W-1:0] k;
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
    for (int p = 0; p < 8; p++) begin
      set_capacity(CAP_W'(cap_plan[p]));
      sender_idle_pct    = send_plan[p % 4];
      receiver_stall_pct = recv_plan[p % 4];
      // keep about half the keys so the new phase still hits old entries
      for (int i = 0; i < POOL_MAX; i++)
        if ($urandom_range(1)) key_pool[i] = $urandom;
      pool_len = $urandom_range(POOL_MAX, 2);
      for (int n = 0; n < 75; n++) begin
        if (n == 40) drain_replies();
        if ($urandom_range(99) < 85) k = key_pool[$urandom_range(pool_len - 1)];
        else k = $urandom;
        send_request($urandom_range(1) ? KIND_PUT : KIND_GET, k, $urandom);
      end
    end
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_get_put();
    test_count_saturation();
    test_capacity_shrink();
    test_victim_tie_break();
    test_capacity_zero();
    test_random_traffic();

    // wait out the pipeline, then give stray replies a chance to show up
    drain_replies();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (pending_replies.size() != 0)
      log_failure($sformatf("%0d replies never arrived", pending_replies.size()));

    $display("run covered %0d requests (%0d gets, %0d puts) with %0d hits and %0d evictions",
             get_count + put_count, get_count, put_count, hit_count, evict_count);
    $display("over %0d capacity writes and four pacing modes; %0d failures",
             cap_writes, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
